// ----- hdl/wsms_pkg.sv -----
// ----------------------------------------------------------------------------
// wsms_pkg
// Shared constants and types for the window sum match search block.
// ----------------------------------------------------------------------------
package wsms_pkg;

	localparam int ELEM_W      = 24;
	localparam int CFG_W       = 30;
	localparam int CFG_IDX_W   = 2;
	localparam int DIM_CFG_W   = 9;
	localparam int WIN_CFG_W   = 4;
	localparam int TARGET_W    = 30;
	localparam int OUT_IDX_W   = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SUM   = 2'd3;

	localparam logic [DIM_CFG_W-1:0] ROW_COUNT_RST    = 9'd1;
	localparam logic [DIM_CFG_W-1:0] COLUMN_COUNT_RST = 9'd1;
	localparam logic [WIN_CFG_W-1:0] WINDOW_SIZE_RST  = 4'd2;
	localparam logic [TARGET_W-1:0]  TARGET_SUM_RST   = 30'd0;

	typedef struct packed {
		logic first_col;
		logic sub_col;
		logic win_ok;
	} wsms_ctl_t;

endpackage

// ----- hdl/wsms_front.sv -----
// ----------------------------------------------------------------------------
// wsms_front
// Config registers, raster position tracking and per-element classification.
// ----------------------------------------------------------------------------
module wsms_front #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256,
	parameter int MAX_WINDOW  = 8,
	localparam int RW  = $clog2(MAX_ROWS),
	localparam int CW  = $clog2(MAX_COLUMNS),
	localparam int H   = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1,
	localparam int SLW = (H > 1) ? $clog2(H) : 1,
	localparam int PW  = $clog2(MAX_WINDOW + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [wsms_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wsms_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [wsms_pkg::ELEM_W-1:0]           element_value,
	input  logic                                  q_ready,
	output logic                                  push,
	output wsms_pkg::wsms_ctl_t                   ctl,
	output logic [wsms_pkg::ELEM_W-1:0]           elem,
	output logic [CW-1:0]                         col,
	output logic [SLW-1:0]                        slot,
	output logic [H-1:0]                          mask,
	output logic [wsms_pkg::OUT_IDX_W-1:0]        mrow,
	output logic [wsms_pkg::OUT_IDX_W-1:0]        mcol,
	output logic [PW-1:0]                         win_p,
	output logic [wsms_pkg::TARGET_W-1:0]         target
);

	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLUMNS + 1);
	localparam int KW  = $clog2(H + 1);

	logic [wsms_pkg::DIM_CFG_W-1:0] rc_q;
	logic [wsms_pkg::DIM_CFG_W-1:0] cc_q;
	logic [wsms_pkg::WIN_CFG_W-1:0] ws_q;
	logic [wsms_pkg::TARGET_W-1:0]  tgt_q;
	logic [RW-1:0]                  r_q;
	logic [CW-1:0]                  c_q;
	logic [SLW-1:0]                 slot_q;

	logic [RCW-1:0] rows;
	logic [CCW-1:0] cols;
	logic [PW-1:0]  p;
	logic           oob;
	logic [RW-1:0]  r_e;
	logic [CW-1:0]  c_e;
	logic [SLW-1:0] slot_e;
	logic           last_col;
	logic           last_row;
	logic [KW-1:0]  kv;

	always_comb begin
		if (rc_q == '0) begin
			rows = RCW'(1);
		end else if (32'(rc_q) > 32'(MAX_ROWS)) begin
			rows = RCW'(MAX_ROWS);
		end else begin
			rows = RCW'(rc_q);
		end
		if (cc_q == '0) begin
			cols = CCW'(1);
		end else if (32'(cc_q) > 32'(MAX_COLUMNS)) begin
			cols = CCW'(MAX_COLUMNS);
		end else begin
			cols = CCW'(cc_q);
		end
		if (ws_q == '0) begin
			p = PW'(1);
		end else if (32'(ws_q) > 32'(MAX_WINDOW)) begin
			p = PW'(MAX_WINDOW);
		end else begin
			p = PW'(ws_q);
		end
	end

	always_comb begin
		oob      = (32'(r_q) >= 32'(rows)) || (32'(c_q) >= 32'(cols));
		r_e      = oob ? '0 : r_q;
		c_e      = oob ? '0 : c_q;
		slot_e   = oob ? '0 : slot_q;
		last_col = (32'(c_e) + 32'd1) >= 32'(cols);
		last_row = (32'(r_e) + 32'd1) >= 32'(rows);
	end

	// history bank b holds row r-k, k counted back from the current slot
	always_comb begin
		kv = '0;
		for (int b = 0; b < H; b++) begin
			if (slot_e == SLW'(b)) begin
				kv = KW'(H);
			end else if (slot_e > SLW'(b)) begin
				kv = KW'(slot_e) - KW'(b);
			end else begin
				kv = KW'(slot_e) + KW'(H - b);
			end
			mask[b] = (32'(kv) < 32'(p)) && (32'(kv) <= 32'(r_e));
		end
	end

	assign in_ready      = q_ready;
	assign push          = in_valid && q_ready;
	assign ctl.first_col = (c_e == '0);
	assign ctl.sub_col   = (32'(c_e) >= 32'(p));
	assign ctl.win_ok    = ((32'(r_e) + 32'd1) >= 32'(p)) && ((32'(c_e) + 32'd1) >= 32'(p));
	assign elem          = element_value;
	assign col           = c_e;
	assign slot          = slot_e;
	assign mrow          = wsms_pkg::OUT_IDX_W'(32'(r_e) + 32'd1 - 32'(p));
	assign mcol          = wsms_pkg::OUT_IDX_W'(32'(c_e) + 32'd1 - 32'(p));
	assign win_p         = p;
	assign target        = tgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q   <= wsms_pkg::ROW_COUNT_RST;
			cc_q   <= wsms_pkg::COLUMN_COUNT_RST;
			ws_q   <= wsms_pkg::WINDOW_SIZE_RST;
			tgt_q  <= wsms_pkg::TARGET_SUM_RST;
			r_q    <= '0;
			c_q    <= '0;
			slot_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wsms_pkg::REG_ROW_COUNT: begin
					rc_q   <= cfg_data[wsms_pkg::DIM_CFG_W-1:0];
					r_q    <= '0;
					c_q    <= '0;
					slot_q <= '0;
				end
				wsms_pkg::REG_COLUMN_COUNT: begin
					cc_q   <= cfg_data[wsms_pkg::DIM_CFG_W-1:0];
					r_q    <= '0;
					c_q    <= '0;
					slot_q <= '0;
				end
				wsms_pkg::REG_WINDOW_SIZE: begin
					ws_q   <= cfg_data[wsms_pkg::WIN_CFG_W-1:0];
					r_q    <= '0;
					c_q    <= '0;
					slot_q <= '0;
				end
				wsms_pkg::REG_TARGET_SUM: begin
					tgt_q <= cfg_data[wsms_pkg::TARGET_W-1:0];
				end
				default: begin
					tgt_q <= tgt_q;
				end
			endcase
		end else if (push) begin
			if (last_col) begin
				c_q <= '0;
				if (last_row) begin
					r_q    <= '0;
					slot_q <= '0;
				end else begin
					r_q    <= r_e + RW'(1);
					slot_q <= (slot_e == SLW'(H - 1)) ? '0 : slot_e + SLW'(1);
				end
			end else begin
				c_q    <= c_e + CW'(1);
				r_q    <= r_e;
				slot_q <= slot_e;
			end
		end
	end

endmodule

// ----- hdl/wsms_queue.sv -----
// ----------------------------------------------------------------------------
// wsms_queue
// Short register FIFO between the classifying front and the summing back.
// ----------------------------------------------------------------------------
module wsms_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         ready,
	output logic         valid,
	input  logic         pop,
	output logic [W-1:0] rdata
);

	localparam int D  = wsms_pkg::QUEUE_DEPTH;
	localparam int PTW = $clog2(D);
	localparam int CNW = $clog2(D + 1);

	logic [W-1:0]   slot_q [D];
	logic [PTW-1:0] wr_q;
	logic [PTW-1:0] rd_q;
	logic [CNW-1:0] cnt_q;

	assign ready = (32'(cnt_q) != 32'(D));
	assign valid = (cnt_q != '0);
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNW'(1);
			end
		end
	end

endmodule

// ----- hdl/wsms_back.sv -----
// ----------------------------------------------------------------------------
// wsms_back
// Line store banks, column sum tree, running row sum and match compare.
// ----------------------------------------------------------------------------
module wsms_back #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_WINDOW  = 8,
	localparam int CW  = $clog2(MAX_COLUMNS),
	localparam int H   = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1,
	localparam int SLW = (H > 1) ? $clog2(H) : 1,
	localparam int PW  = $clog2(MAX_WINDOW + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           pop,
	input  wsms_pkg::wsms_ctl_t            q_ctl,
	input  logic [wsms_pkg::ELEM_W-1:0]    q_elem,
	input  logic [CW-1:0]                  q_col,
	input  logic [SLW-1:0]                 q_slot,
	input  logic [H-1:0]                   q_mask,
	input  logic [wsms_pkg::OUT_IDX_W-1:0] q_mrow,
	input  logic [wsms_pkg::OUT_IDX_W-1:0] q_mcol,
	input  logic [PW-1:0]                  win_p,
	input  logic [wsms_pkg::TARGET_W-1:0]  target,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [wsms_pkg::OUT_IDX_W-1:0] match_row,
	output logic [wsms_pkg::OUT_IDX_W-1:0] match_column
);

	localparam int EW   = wsms_pkg::ELEM_W;
	localparam int NT   = H + 1;
	localparam int G    = (NT + 3) / 4;
	localparam int GW   = EW + 2;
	localparam int XW   = EW + $clog2(MAX_WINDOW);
	localparam int SW   = EW + 2 * $clog2(MAX_WINDOW);
	localparam int CMPW = (SW > wsms_pkg::TARGET_W) ? SW : wsms_pkg::TARGET_W;
	localparam int LW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int OW   = wsms_pkg::OUT_IDX_W;

	logic adv;

	logic                  valid_s1;
	wsms_pkg::wsms_ctl_t   ctl_s1;
	logic [EW-1:0]         v_s1;
	logic [H-1:0]          mask_s1;
	logic [H-1:0][EW-1:0]  rd_s1;
	logic [OW-1:0]         mrow_s1;
	logic [OW-1:0]         mcol_s1;

	logic [NT-1:0][EW-1:0] term;
	logic [G-1:0][GW-1:0]  grp;
	logic                  valid_s2;
	wsms_pkg::wsms_ctl_t   ctl_s2;
	logic [G-1:0][GW-1:0]  grp_s2;
	logic [OW-1:0]         mrow_s2;
	logic [OW-1:0]         mcol_s2;

	logic [XW-1:0]         colwin;
	logic                  valid_s3;
	wsms_pkg::wsms_ctl_t   ctl_s3;
	logic [XW-1:0]         colwin_s3;
	logic [OW-1:0]         mrow_s3;
	logic [OW-1:0]         mcol_s3;

	logic [MAX_WINDOW-1:0][XW-1:0] line_q;
	logic [XW-1:0]         old_col;
	logic [SW-1:0]         rws_nxt;
	logic [SW-1:0]         rws_q;
	logic                  valid_s4;
	logic                  win_ok_s4;
	logic [OW-1:0]         mrow_s4;
	logic [OW-1:0]         mcol_s4;

	logic                  out_valid_q;
	logic [OW-1:0]         match_row_q;
	logic [OW-1:0]         match_column_q;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && q_valid;

	// one bank per history row: one read and one write per cycle while adv is high
	for (genvar b = 0; b < H; b++) begin : g_bank
		logic [EW-1:0] mem [MAX_COLUMNS];
		always_ff @(posedge clk) begin
			if (adv) begin
				if (q_valid && (q_slot == SLW'(b))) begin
					mem[q_col] <= q_elem;
				end
				rd_s1[b] <= mem[q_col];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1  <= q_ctl;
			v_s1    <= q_elem;
			mask_s1 <= q_mask;
			mrow_s1 <= q_mrow;
			mcol_s1 <= q_mcol;
		end
	end

	always_comb begin
		term[0] = v_s1;
		for (int b = 0; b < H; b++) begin
			term[b+1] = mask_s1[b] ? rd_s1[b] : '0;
		end
		for (int g = 0; g < G; g++) begin
			grp[g] = '0;
			for (int t = 0; t < 4; t++) begin
				if (4 * g + t < NT) begin
					grp[g] = grp[g] + GW'(term[4*g+t]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2  <= ctl_s1;
			grp_s2  <= grp;
			mrow_s2 <= mrow_s1;
			mcol_s2 <= mcol_s1;
		end
	end

	always_comb begin
		colwin = '0;
		for (int g = 0; g < G; g++) begin
			colwin = colwin + XW'(grp_s2[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3    <= ctl_s2;
			colwin_s3 <= colwin;
			mrow_s3   <= mrow_s2;
			mcol_s3   <= mcol_s2;
		end
	end

	always_comb begin
		old_col = ctl_s3.sub_col ? line_q[LW'(win_p - PW'(1))] : '0;
		rws_nxt = (ctl_s3.first_col ? '0 : rws_q) + SW'(colwin_s3) - SW'(old_col);
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			line_q[0] <= colwin_s3;
			for (int i = 1; i < MAX_WINDOW; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
		if (adv) begin
			win_ok_s4      <= ctl_s3.win_ok;
			mrow_s4        <= mrow_s3;
			mcol_s4        <= mcol_s3;
			match_row_q    <= mrow_s4;
			match_column_q <= mcol_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			rws_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= q_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			if (valid_s3) begin
				rws_q <= rws_nxt;
			end
			out_valid_q <= valid_s4 && win_ok_s4 && (CMPW'(rws_q) == CMPW'(target));
		end
	end

	assign out_valid    = out_valid_q;
	assign match_row    = match_row_q;
	assign match_column = match_column_q;

endmodule

// ----- hdl/window_sum_match_search.sv -----
// ----------------------------------------------------------------------------
// window_sum_match_search
// Streaming p-by-p window sum search over a raster-order matrix.
// A match goes out after its last element passes the queue and stages s1 to s4.
// Throughput: one element per cycle unless out_ready stalls; the row-sum
// accumulator is a registered loop; line banks read and write once per cycle.
// Reset: config back to defaults, position to row 0 column 0; line stores
// are not cleared.
// ----------------------------------------------------------------------------
module window_sum_match_search #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256,
	parameter int MAX_WINDOW  = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [wsms_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wsms_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [wsms_pkg::ELEM_W-1:0]           element_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [wsms_pkg::OUT_IDX_W-1:0]        match_row,
	output logic [wsms_pkg::OUT_IDX_W-1:0]        match_column
);

	localparam int CW  = $clog2(MAX_COLUMNS);
	localparam int H   = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
	localparam int SLW = (H > 1) ? $clog2(H) : 1;
	localparam int PW  = $clog2(MAX_WINDOW + 1);
	localparam int OW  = wsms_pkg::OUT_IDX_W;
	localparam int EW  = wsms_pkg::ELEM_W;
	localparam int CTW = $bits(wsms_pkg::wsms_ctl_t);
	localparam int QW  = CTW + EW + CW + SLW + H + 2 * OW;

	logic                         q_ready;
	logic                         push;
	wsms_pkg::wsms_ctl_t          f_ctl;
	logic [EW-1:0]                f_elem;
	logic [CW-1:0]                f_col;
	logic [SLW-1:0]               f_slot;
	logic [H-1:0]                 f_mask;
	logic [OW-1:0]                f_mrow;
	logic [OW-1:0]                f_mcol;
	logic [PW-1:0]                win_p;
	logic [wsms_pkg::TARGET_W-1:0] target;

	logic                         q_valid;
	logic                         pop;
	logic [QW-1:0]                q_wdata;
	logic [QW-1:0]                q_rdata;
	wsms_pkg::wsms_ctl_t          b_ctl;
	logic [EW-1:0]                b_elem;
	logic [CW-1:0]                b_col;
	logic [SLW-1:0]               b_slot;
	logic [H-1:0]                 b_mask;
	logic [OW-1:0]                b_mrow;
	logic [OW-1:0]                b_mcol;

	wsms_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS),
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element_value(element_value),
		.q_ready      (q_ready),
		.push         (push),
		.ctl          (f_ctl),
		.elem         (f_elem),
		.col          (f_col),
		.slot         (f_slot),
		.mask         (f_mask),
		.mrow         (f_mrow),
		.mcol         (f_mcol),
		.win_p        (win_p),
		.target       (target)
	);

	assign q_wdata = {f_ctl, f_elem, f_col, f_slot, f_mask, f_mrow, f_mcol};

	wsms_queue #(
		.W(QW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (q_wdata),
		.ready (q_ready),
		.valid (q_valid),
		.pop   (pop),
		.rdata (q_rdata)
	);

	assign {b_ctl, b_elem, b_col, b_slot, b_mask, b_mrow, b_mcol} = q_rdata;

	wsms_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.pop         (pop),
		.q_ctl       (b_ctl),
		.q_elem      (b_elem),
		.q_col       (b_col),
		.q_slot      (b_slot),
		.q_mask      (b_mask),
		.q_mrow      (b_mrow),
		.q_mcol      (b_mcol),
		.win_p       (win_p),
		.target      (target),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.match_row   (match_row),
		.match_column(match_column)
	);

endmodule
